FILE: rtl/sapc_pkg.sv
package sapc_pkg;

  localparam int SAMPLE_W = 15;
  localparam int SLOPE_W  = 16;
  localparam int CNT_W    = 24;
  localparam int STEP_W   = 10;
  localparam int SUM_W    = 40;
  localparam int THR_W    = 18;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam int THRESH_SHIFT = 13;

  localparam int RING_DEPTH_DEF    = 64;
  localparam int WINDOW_DEF        = 32;
  localparam int WINDOW_OFFSET_DEF = 0;

  localparam logic [CNT_W-1:0] LEARN_TIME_RST   = 24'd10000;
  localparam logic [CNT_W-1:0] QUIET_LIMIT_RST  = 24'd20000;
  localparam logic [CNT_W-1:0] IGNORE_LIMIT_RST = 24'd2000;
  localparam logic [STEP_W-1:0] SAMPLE_STEP_RST = 10'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP  = 2'd3;

  localparam logic [1:0] MODE_LEARN  = 2'd0;
  localparam logic [1:0] MODE_DETECT = 2'd1;
  localparam logic [1:0] MODE_IGNORE = 2'd2;
  localparam logic [1:0] MODE_PACE   = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  learn_time;
    logic [CNT_W-1:0]  quiet_limit;
    logic [CNT_W-1:0]  ignore_limit;
    logic [STEP_W-1:0] sample_step;
  } sapc_cfg_t;

  typedef struct packed {
    logic fill_step;
    logic eval;
  } sapc_ctl_t;

  typedef struct packed {
    logic                      pace;
    logic [1:0]                mode;
    logic signed [SLOPE_W-1:0] min_slope;
    logic                      activation;
  } sapc_res_t;

endpackage

FILE: rtl/sapc_ifs.sv
interface sapc_in_if;
  import sapc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sapc_out_if;
  import sapc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      pace;
  logic [1:0]                mode;
  logic signed [SLOPE_W-1:0] min_slope;
  logic                      activation;
  modport source (output valid, output pace, output mode, output min_slope,
                  output activation, input ready);
  modport sink (input valid, input pace, input mode, input min_slope,
                input activation, output ready);
endinterface

FILE: rtl/slope_activation_pacing_controller.sv
// one item per cycle while the ring fills; no result is given then
// once full, ready drops on acceptance, so a new item is not taken until the
// window walk (one ring read a cycle over WINDOW entries) and the result load have finished
// the result stands in an output register, loaded after the walk when the output is free
// synchronous active-low reset clears control, counters, mode and the output valid flag
// and loads config defaults; ring contents and data registers are kept; no clearing pass runs
module slope_activation_pacing_controller #(
  parameter int RING_DEPTH    = sapc_pkg::RING_DEPTH_DEF,
  parameter int WINDOW        = sapc_pkg::WINDOW_DEF,
  parameter int WINDOW_OFFSET = sapc_pkg::WINDOW_OFFSET_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  sapc_in_if.sink                               in_ch,
  sapc_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [sapc_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [sapc_pkg::CFG_W-1:0]            cfg_wdata
);
  import sapc_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] DEPTH_M1 = AW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(RING_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [AW-1:0]             wp_r;
  logic [FW-1:0]             fill_r;
  logic                      full;
  logic                      in_acc;
  logic                      out_free;
  sapc_cfg_t                 cfg_r;
  sapc_ctl_t                 ctl;
  sapc_res_t                 res;
  logic                      out_valid_r;
  sapc_res_t                 out_r;
  logic [AW-1:0]             raddr;
  logic signed [SAMPLE_W-1:0] rdata;
  logic                      walk_done;
  logic signed [SLOPE_W-1:0] walk_slope;

  assign full     = (fill_r == FULL_CNT);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign ctl.fill_step = in_acc && !full;
  assign ctl.eval      = (state_r == S_EVAL) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && full) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_r.learn_time   <= LEARN_TIME_RST;
      cfg_r.quiet_limit  <= QUIET_LIMIT_RST;
      cfg_r.ignore_limit <= IGNORE_LIMIT_RST;
      cfg_r.sample_step  <= SAMPLE_STEP_RST;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        wp_r <= (wp_r == DEPTH_M1) ? '0 : (wp_r + AW'(1));
        if (!full) begin
          fill_r <= fill_r + FW'(1);
        end
      end
      if (ctl.eval) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_LEARN_TIME:   cfg_r.learn_time   <= cfg_wdata;
          CFG_QUIET_LIMIT:  cfg_r.quiet_limit  <= cfg_wdata;
          CFG_IGNORE_LIMIT: cfg_r.ignore_limit <= cfg_wdata;
          CFG_SAMPLE_STEP:  cfg_r.sample_step  <= cfg_wdata[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      out_r <= res;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pace       = out_r.pace;
  assign out_ch.mode       = out_r.mode;
  assign out_ch.min_slope  = out_r.min_slope;
  assign out_ch.activation = out_r.activation;

  sapc_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (wp_r),
    .wdata   (in_ch.sample),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  sapc_walk #(
    .DEPTH  (RING_DEPTH),
    .WINDOW (WINDOW),
    .OFFSET (WINDOW_OFFSET),
    .AW     (AW)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && full),
    .newest    (wp_r),
    .raddr     (raddr),
    .rdata     (rdata),
    .done      (walk_done),
    .min_slope (walk_slope)
  );

  sapc_mode u_mode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ctl       (ctl),
    .min_slope (walk_slope),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |-> state_r == S_WALK)
    else $error("window walk finished outside the walk state");
  a_fill_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !full) |=> state_r == S_IDLE)
    else $error("item during ring fill started a window walk");
  a_eval_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.eval |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over an untaken result");
`endif

endmodule

FILE: rtl/sapc_ring.sv
module sapc_ring #(
  parameter int DEPTH = sapc_pkg::RING_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic signed [sapc_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                        raddr,
  output logic signed [sapc_pkg::SAMPLE_W-1:0] rdata_r
);
  import sapc_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/sapc_walk.sv
module sapc_walk #(
  parameter int DEPTH  = sapc_pkg::RING_DEPTH_DEF,
  parameter int WINDOW = sapc_pkg::WINDOW_DEF,
  parameter int OFFSET = sapc_pkg::WINDOW_OFFSET_DEF,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [AW-1:0]                        newest,
  output logic [AW-1:0]                        raddr,
  input  logic signed [sapc_pkg::SAMPLE_W-1:0] rdata,
  output logic                                 done,
  output logic signed [sapc_pkg::SLOPE_W-1:0]  min_slope
);
  import sapc_pkg::*;

  localparam int CW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [AW-1:0] OFF_MOD  = AW'(OFFSET % DEPTH);
  localparam logic [AW-1:0] DEPTH_M1 = AW'(DEPTH - 1);
  localparam logic [AW-1:0] WRAP_ADD = AW'(DEPTH - (OFFSET % DEPTH));
  localparam logic [CW-1:0] LAST     = CW'(WINDOW - 1);

  logic                       busy_r, busy_nxt;
  logic [AW-1:0]              raddr_r, raddr_nxt;
  logic [CW-1:0]              icnt_r, icnt_nxt;
  logic                       rvld_r;
  logic [CW-1:0]              dcnt_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SLOPE_W-1:0]  best_r;
  logic                       done_r;
  logic [AW-1:0]              first_addr;
  logic signed [SLOPE_W-1:0]  diff;

  // newest entry of the window lies the offset back from the newest sample
  assign first_addr = (newest >= OFF_MOD) ? (newest - OFF_MOD) : (newest + WRAP_ADD);

  always_comb begin
    busy_nxt  = busy_r;
    raddr_nxt = raddr_r;
    icnt_nxt  = icnt_r;
    if (start) begin
      busy_nxt  = 1'b1;
      raddr_nxt = first_addr;
      icnt_nxt  = '0;
    end else if (busy_r) begin
      raddr_nxt = (raddr_r == '0) ? DEPTH_M1 : (raddr_r - AW'(1));
      icnt_nxt  = icnt_r + CW'(1);
      if (icnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign diff = SLOPE_W'(prev_r) - SLOPE_W'(rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rvld_r <= 1'b0;
      done_r <= 1'b0;
      dcnt_r <= '0;
      icnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      icnt_r <= icnt_nxt;
      rvld_r <= busy_r;
      done_r <= 1'b0;
      if (start) begin
        dcnt_r <= '0;
      end else if (rvld_r) begin
        dcnt_r <= dcnt_r + CW'(1);
        if (dcnt_r == LAST) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_r <= raddr_nxt;
    if (rvld_r) begin
      prev_r <= rdata;
      if (dcnt_r != '0) begin
        if (dcnt_r == CW'(1) || diff < best_r) begin
          best_r <= diff;
        end
      end
    end
  end

  assign raddr     = raddr_r;
  assign done      = done_r;
  assign min_slope = best_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && !rvld_r)
    else $error("window walk finished with reads still in flight");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r && !rvld_r)
    else $error("window walk restarted while busy");
  a_rvld_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> rvld_r)
    else $error("read data not marked valid after a read");
`endif

endmodule

FILE: rtl/sapc_mode.sv
module sapc_mode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sapc_pkg::sapc_cfg_t                 cfg,
  input  sapc_pkg::sapc_ctl_t                 ctl,
  input  logic signed [sapc_pkg::SLOPE_W-1:0] min_slope,
  output sapc_pkg::sapc_res_t                 res
);
  import sapc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [THR_W-1:0] THR_MAX = {1'b0, {(THR_W-1){1'b1}}};
  localparam logic signed [THR_W-1:0] THR_MIN = {1'b1, {(THR_W-1){1'b0}}};

  logic [1:0]              mode_r, mode_nxt;
  logic [CNT_W-1:0]        elapsed_r, quiet_r, ignore_r;
  logic [CNT_W-1:0]        quiet_base, ignore_base;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [THR_W-1:0] thr_r, thr_nxt;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] shifted;
  logic                    act_cmp, act;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [STEP_W-1:0] s);
    logic [CNT_W:0] t;
    t = {1'b0, c} + (CNT_W+1)'(s);
    return t[CNT_W] ? CNT_MAX : t[CNT_W-1:0];
  endfunction

  assign act_cmp  = THR_W'(min_slope) < thr_r;
  assign sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(min_slope);
  assign shifted  = sum_r >>> THRESH_SHIFT;

  always_comb begin
    mode_nxt    = mode_r;
    sum_nxt     = sum_r;
    thr_nxt     = thr_r;
    quiet_base  = quiet_r;
    ignore_base = ignore_r;
    act         = 1'b0;
    case (mode_r)
      MODE_LEARN: begin
        if (elapsed_r < cfg.learn_time) begin
          if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_nxt = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
          end else begin
            sum_nxt = sum_wide[SUM_W-1:0];
          end
        end else begin
          // threshold from the learnt sum, saturated to its own width
          if (shifted[SUM_W-1] && !(&shifted[SUM_W-2:THR_W-1])) begin
            thr_nxt = THR_MIN;
          end else if (!shifted[SUM_W-1] && (|shifted[SUM_W-2:THR_W-1])) begin
            thr_nxt = THR_MAX;
          end else begin
            thr_nxt = shifted[THR_W-1:0];
          end
          quiet_base = '0;
          mode_nxt   = MODE_DETECT;
        end
      end
      MODE_DETECT: begin
        act = act_cmp;
        if (quiet_r <= cfg.quiet_limit) begin
          if (act_cmp) begin
            quiet_base  = '0;
            ignore_base = '0;
            mode_nxt    = MODE_IGNORE;
          end
        end else begin
          mode_nxt = MODE_PACE;
        end
      end
      MODE_IGNORE: begin
        if (ignore_r > cfg.ignore_limit) begin
          mode_nxt = MODE_DETECT;
        end
      end
      MODE_PACE: begin
        act = act_cmp;
        if (act_cmp) begin
          quiet_base  = '0;
          ignore_base = '0;
          mode_nxt    = MODE_IGNORE;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LEARN;
      elapsed_r <= '0;
      quiet_r   <= '0;
      ignore_r  <= '0;
      sum_r     <= '0;
      thr_r     <= '0;
    end else if (ctl.eval) begin
      mode_r    <= mode_nxt;
      sum_r     <= sum_nxt;
      thr_r     <= thr_nxt;
      elapsed_r <= sat_add(elapsed_r, cfg.sample_step);
      quiet_r   <= sat_add(quiet_base, cfg.sample_step);
      ignore_r  <= sat_add(ignore_base, cfg.sample_step);
    end else if (ctl.fill_step) begin
      elapsed_r <= sat_add(elapsed_r, cfg.sample_step);
    end
  end

  assign res.pace       = (mode_nxt == MODE_PACE);
  assign res.mode       = mode_nxt;
  assign res.min_slope  = min_slope;
  assign res.activation = act;

endmodule
